// File: rtl/core/u8l1_pkg.sv
// shared types and constants of the utf-8 to latin-1 transcoder
package u8l1_pkg;

    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CountW    = $clog2(FifoDepth + 1);

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD_C2     = 8'hC2;
    localparam logic [7:0] LEAD_C3     = 8'hC3;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_INVALID    = 2'd1;
    localparam logic [1:0] STATUS_NOT_LATIN1 = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] RANGE_80_BF = 3'd0;
    localparam logic [2:0] RANGE_A0_BF = 3'd1;
    localparam logic [2:0] RANGE_80_9F = 3'd2;
    localparam logic [2:0] RANGE_90_BF = 3'd3;
    localparam logic [2:0] RANGE_80_8F = 3'd4;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } t_result;

endpackage

// File: rtl/core/utf8_to_latin1_transcoder.sv
// utf-8 to latin-1 transcoder: validates a byte stream and emits latin-1 bytes and a status
//
// Takes one UTF-8 byte per cycle on the slave stream, tlast marking the last byte of a text.
// Each byte is held in an input register and checked in a single pass of shallow logic; the
// zero, one or two results it causes (a Latin-1 data byte and, on the last byte, a status
// transfer with tuser high and status 0 ok, 1 invalid UTF-8, 2 not Latin-1) go into a four-entry
// result queue that drives the master stream. A byte is taken every cycle as long as the queue
// has room for two results, so the sustained rate is one byte per cycle whenever each byte yields
// at most one result and the consumer keeps up; a result reaches the master stream once its byte
// has passed the input register and been written into the result queue. Data bytes of a text
// whose status is not ok are to be dropped by the consumer.
module utf8_to_latin1_transcoder
    import u8l1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte [7:0], status [9:8], zero [15:10]
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser    // out_kind
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_end;

    logic [1:0]        r_cont, n_cont;
    logic [2:0]        r_cls, n_cls;
    logic              r_pend, n_pend;
    logic [1:0]        r_hi, n_hi;
    logic              r_inv, n_inv;
    logic              r_nl, n_nl;

    t_result           r_fifo [FifoDepth];
    logic [PtrW-1:0]   r_wp, r_rp;
    logic [CountW-1:0] r_count, n_count;

    logic              w_advance;
    logic              w_pop;
    logic              w_cont_ok;
    logic              w_have;
    logic [7:0]        w_data;
    logic [1:0]        w_status;
    t_result           w_res0, w_res1;
    logic [1:0]        w_num;

    assign w_advance     = r_in_valid && (r_count <= CountW'(FifoDepth - 2));
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    always_comb begin
        case (r_cls)
            RANGE_A0_BF: w_cont_ok = r_in_byte inside {[8'hA0:8'hBF]};
            RANGE_80_9F: w_cont_ok = r_in_byte inside {[8'h80:8'h9F]};
            RANGE_90_BF: w_cont_ok = r_in_byte inside {[8'h90:8'hBF]};
            RANGE_80_8F: w_cont_ok = r_in_byte inside {[8'h80:8'h8F]};
            default:     w_cont_ok = r_in_byte inside {[8'h80:8'hBF]};
        endcase
    end

    always_comb begin
        n_cont = r_cont;
        n_cls  = r_cls;
        n_pend = r_pend;
        n_hi   = r_hi;
        n_inv  = r_inv;
        n_nl   = r_nl;
        w_have = 1'b0;
        w_data = 8'd0;
        if (!r_inv) begin
            if (r_cont != 2'd0) begin
                if (w_cont_ok) begin
                    n_cont = r_cont - 2'd1;
                    n_cls  = RANGE_80_BF;
                    if (r_pend) begin
                        n_pend = 1'b0;
                        w_data = {r_hi, r_in_byte[5:0]};
                        w_have = !r_nl;
                    end
                end else begin
                    n_inv = 1'b1;
                end
            end else if (r_in_byte < ASCII_LIMIT) begin
                w_data = r_in_byte;
                w_have = !r_nl;
            end else if (r_in_byte < LEAD_C2) begin
                n_inv = 1'b1;
            end else if (r_in_byte <= LEAD_C3) begin
                n_cont = 2'd1;
                n_cls  = RANGE_80_BF;
                n_pend = 1'b1;
                n_hi   = r_in_byte[1:0];
            end else if (r_in_byte <= 8'hDF) begin
                n_cont = 2'd1;
                n_cls  = RANGE_80_BF;
                n_nl   = 1'b1;
            end else if (r_in_byte <= 8'hEF) begin
                n_cont = 2'd2;
                n_cls  = (r_in_byte == LEAD_E0) ? RANGE_A0_BF :
                         (r_in_byte == LEAD_ED) ? RANGE_80_9F : RANGE_80_BF;
                n_nl   = 1'b1;
            end else if (r_in_byte <= LEAD_F4) begin
                n_cont = 2'd3;
                n_cls  = (r_in_byte == LEAD_F0) ? RANGE_90_BF :
                         (r_in_byte == LEAD_F4) ? RANGE_80_8F : RANGE_80_BF;
                n_nl   = 1'b1;
            end else begin
                n_inv = 1'b1;
            end
        end
        if (n_inv) begin
            w_have = 1'b0;
        end
        if (n_inv || (n_cont != 2'd0)) begin
            w_status = STATUS_INVALID;
        end else if (n_nl) begin
            w_status = STATUS_NOT_LATIN1;
        end else begin
            w_status = STATUS_OK;
        end
        if (r_in_end) begin
            n_cont = 2'd0;
            n_cls  = RANGE_80_BF;
            n_pend = 1'b0;
            n_hi   = 2'd0;
            n_inv  = 1'b0;
            n_nl   = 1'b0;
        end
    end

    // result list for this byte: optional data byte, then status on end of text
    always_comb begin
        t_result stat;
        stat = '{kind: KIND_STATUS, data: 8'd0, status: w_status, last: 1'b1};
        w_res1 = stat;
        if (w_have) begin
            w_res0 = '{kind: KIND_DATA, data: w_data, status: STATUS_OK, last: !r_in_end};
            w_num  = r_in_end ? 2'd2 : 2'd1;
        end else begin
            w_res0 = stat;
            w_num  = r_in_end ? 2'd1 : 2'd0;
        end
    end

    assign n_count = r_count + (w_advance ? CountW'(w_num) : CountW'(0)) - CountW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cont     <= 2'd0;
            r_cls      <= RANGE_80_BF;
            r_pend     <= 1'b0;
            r_hi       <= 2'd0;
            r_inv      <= 1'b0;
            r_nl       <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_count    <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_cont <= n_cont;
                r_cls  <= n_cls;
                r_pend <= n_pend;
                r_hi   <= n_hi;
                r_inv  <= n_inv;
                r_nl   <= n_nl;
                r_wp   <= r_wp + PtrW'(w_num);
            end
            if (w_pop) begin
                r_rp <= r_rp + PtrW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
        if (w_advance && (w_num != 2'd0)) begin
            r_fifo[r_wp] <= w_res0;
        end
        if (w_advance && (w_num == 2'd2)) begin
            r_fifo[r_wp + PtrW'(1)] <= w_res1;
        end
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {6'd0, r_fifo[r_rp].status, r_fifo[r_rp].data};
    assign m_axis_tlast  = r_fifo[r_rp].last;
    assign m_axis_tuser  = r_fifo[r_rp].kind;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(FifoDepth))
        else $error("result queue overflow");

    a_held_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_end)))
        else $error("stalled input byte lost");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'd0)))
        else $error("status transfer malformed");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:8] == STATUS_OK))
        else $error("data transfer carries status");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_end) |=> ((r_cont == 2'd0) && !r_inv && !r_nl && !r_pend))
        else $error("state not cleared after end of text");

endmodule
